@@ design/dhc_pkg.sv @@
// Shared types and constants for the depth-to-hue colormap.
package dhc_pkg;

	localparam int DEPTH_BITS = 14;

	// 1530 = 360*255/60 needs 11 bits, so 1530*depth fits in DEPTH_BITS+11 bits
	localparam int MUL_BITS   = 11;
	localparam int NUM_BITS   = DEPTH_BITS + MUL_BITS;
	localparam int CNT_BITS   = $clog2(NUM_BITS);

	localparam logic [MUL_BITS-1:0] HUE_MUL = MUL_BITS'(360 * 255 / 60);

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
	localparam logic [DEPTH_BITS-1:0] RESET_SCALE =
		(6000 > (2 ** DEPTH_BITS) - 1) ? DEPTH_MAX : DEPTH_BITS'(6000);

	localparam logic [7:0] FULL     = 8'hFF;
	localparam logic [9:0] TWO_FULL = 10'd510;

	typedef struct packed {
		logic [DEPTH_BITS-1:0] depth_mm;
		logic                  frame_end;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic write_out;
	} dhc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic white;
		logic out_busy;
	} dhc_status_t;

endpackage

@@ design/dhc_ctrl.sv @@
// Sequencer for the depth-to-hue colormap: accept, divide, write result.
module dhc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  dhc_pkg::dhc_status_t status,
	output dhc_pkg::dhc_cmd_t   cmd
);
	import dhc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [1:0]          state_d;
	logic [CNT_BITS-1:0] cnt_q;

	assign pixel_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.step      = 1'b0;
		cmd.write_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pixel_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.white) begin
					state_d = ST_DONE;
				end else begin
					cmd.step = 1'b1;
					if (cnt_q == '0) state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.write_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) cnt_q <= CNT_BITS'(NUM_BITS - 1);
			else if (cmd.step) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/dhc_datapath.sv @@
// Datapath: frame scale tracking, bit-serial hue divider and sector mapping.
module dhc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dhc_pkg::pixel_t      pixel,
	input  dhc_pkg::dhc_cmd_t    cmd,
	output dhc_pkg::dhc_status_t status,
	output logic                 color_valid,
	input  logic                 color_stall,
	output dhc_pkg::color_t      color
);
	import dhc_pkg::*;

	logic [DEPTH_BITS-1:0] scale_q;
	logic [DEPTH_BITS-1:0] max_q;
	logic [DEPTH_BITS-1:0] div_q;
	logic [NUM_BITS-1:0]   num_q;
	logic [DEPTH_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0]   quo_q;
	logic [8:0]            mod_q;
	logic                  white_q;
	logic                  out_valid_q;
	color_t                out_q;

	logic [DEPTH_BITS-1:0] new_max;
	logic [DEPTH_BITS:0]   trial;
	logic                  qbit;
	logic [DEPTH_BITS-1:0] rem_next;
	logic [9:0]            mod_trial;
	logic [8:0]            mod_next;
	logic [7:0]            hue_dev;
	logic [7:0]            x;
	color_t                rgb;

	assign new_max = (pixel.depth_mm > max_q) ? pixel.depth_mm : max_q;

	// one restoring division step; remainder by 510 follows the quotient bits
	always_comb begin
		trial    = {rem_q, num_q[NUM_BITS-1]};
		qbit     = (trial >= {1'b0, div_q});
		// remainder stays below the divisor, so it fits in DEPTH_BITS
		rem_next = qbit ? DEPTH_BITS'(trial - {1'b0, div_q}) : trial[DEPTH_BITS-1:0];
		mod_trial = {mod_q, qbit};
		mod_next  = (mod_trial >= TWO_FULL) ? 9'(mod_trial - TWO_FULL) : mod_trial[8:0];
	end

	// six-sector hue rule
	always_comb begin
		hue_dev = (mod_q >= 9'(FULL)) ? 8'(mod_q - 9'(FULL)) : 8'(9'(FULL) - mod_q);
		x       = FULL - hue_dev;
		priority if (white_q) begin
			rgb = '{FULL, FULL, FULL};
		end else if (quo_q < NUM_BITS'(1 * 255)) begin
			rgb = '{FULL, x, 8'd0};
		end else if (quo_q < NUM_BITS'(2 * 255)) begin
			rgb = '{x, FULL, 8'd0};
		end else if (quo_q < NUM_BITS'(3 * 255)) begin
			rgb = '{8'd0, FULL, x};
		end else if (quo_q < NUM_BITS'(4 * 255)) begin
			rgb = '{8'd0, x, FULL};
		end else if (quo_q < NUM_BITS'(5 * 255)) begin
			rgb = '{x, 8'd0, FULL};
		end else begin
			rgb = '{FULL, 8'd0, x};
		end
	end

	// frame statistics and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= RESET_SCALE;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (pixel.frame_end) begin
					scale_q <= new_max;
					max_q   <= '0;
				end else begin
					max_q <= new_max;
				end
			end
			if (cmd.write_out) out_valid_q <= 1'b1;
			else if (!color_stall) out_valid_q <= 1'b0;
		end
	end

	// divider registers and result beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q   <= scale_q;
			white_q <= (pixel.depth_mm == '0) || (scale_q == '0);
			num_q   <= NUM_BITS'(pixel.depth_mm) * NUM_BITS'(HUE_MUL);
			rem_q   <= '0;
			quo_q   <= '0;
			mod_q   <= '0;
		end else if (cmd.step) begin
			num_q <= {num_q[NUM_BITS-2:0], 1'b0};
			rem_q <= rem_next;
			quo_q <= {quo_q[NUM_BITS-2:0], qbit};
			mod_q <= mod_next;
		end
		if (cmd.write_out) out_q <= rgb;
	end

	assign status.white    = white_q;
	assign status.out_busy = out_valid_q && color_stall;
	assign color_valid     = out_valid_q;
	assign color           = out_q;

endmodule

@@ design/depth_to_hue_colormap.sv @@
// Top level of the depth-to-hue false-color map: controller plus datapath.
//
// Each pixel beat becomes one RGB beat. The hue h = floor(1530*depth/scale) comes
// from a restoring divider that yields one quotient bit per cycle, and the next
// pixel is accepted only after the result is written to the output register; a
// result still stalled at the output delays the write and so the next acceptance.
// Pixels with depth 0, or any pixel while the scale is 0, skip the divider and
// come out white. The scale is the largest depth of the previous frame (6000
// after reset); the pixel marked frame_end is still colored with the old scale.
// One result can wait in the output register while the next pixel is accepted
// and divided.
module depth_to_hue_colormap (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  dhc_pkg::pixel_t  pixel,
	output logic             color_valid,
	input  logic             color_stall,
	output dhc_pkg::color_t  color
);
	import dhc_pkg::*;

	dhc_cmd_t    cmd;
	dhc_status_t status;

	dhc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.status      (status),
		.cmd         (cmd)
	);

	dhc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel       (pixel),
		.cmd         (cmd),
		.status      (status),
		.color_valid (color_valid),
		.color_stall (color_stall),
		.color       (color)
	);

	// a new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> !(color_valid && color_stall))
		else $error("result written over a stalled beat");

	// loading happens only on an accepted pixel beat
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (pixel_valid && !pixel_stall))
		else $error("load without accepted pixel");

	// once a pixel is taken the input stalls until its result is written
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) |=> pixel_stall)
		else $error("input not stalled after accept");

	// the divider never steps in the same cycle the result is written
	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.write_out))
		else $error("divider step during result write");

endmodule

@@ test/depth_to_hue_colormap_test.sv @@
// Self-checking testbench for the depth-to-hue colormap: random bursts, stalls and frames.
module depth_to_hue_colormap_test;

	import dhc_pkg::*;

	localparam int PIXEL_COUNT = 1450;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_t;

	typedef struct {
		pixel_t px;
		bit     drain_first;
	} queued_pixel_t;

	logic   clk;
	logic   arst_n = 1'b0;
	logic   pixel_valid = 1'b0;
	logic   pixel_stall;
	pixel_t pixel = '0;
	logic   color_valid;
	logic   color_stall = 1'b0;
	color_t color;

	queued_pixel_t pixel_queue[$];
	color_t        expected_colors[$];
	int            errors = 0;
	int            cycles = 0;

	// colormap state as the block should hold it
	logic [DEPTH_BITS-1:0] scale_now = 14'd6000;
	logic [DEPTH_BITS-1:0] frame_peak = '0;

	// sender pacing
	int burst_left = 1;
	int gap_left = 0;

	// receiver pacing
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          hold_left = 0;
	logic        held = 1'b0;

	depth_to_hue_colormap i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.color_valid (color_valid),
		.color_stall (color_stall),
		.color       (color)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// full-saturation hue wheel, h = floor(1530*depth/scale)
	function automatic color_t hue_color(input logic [DEPTH_BITS-1:0] depth,
			input logic [DEPTH_BITS-1:0] scale);
		longint unsigned h;
		int unsigned     m;
		logic [7:0]      x;
		color_t          c;
		c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
		if (depth != 0 && scale != 0) begin
			h = (64'd91800 * depth / scale) / 60;
			m = int'(h % 510);
			x = 8'(255 - ((m >= 255) ? m - 255 : 255 - m));
			if (h < 255)
				c = '{red: 8'd255, green: x, blue: 8'd0};
			else if (h < 510)
				c = '{red: x, green: 8'd255, blue: 8'd0};
			else if (h < 765)
				c = '{red: 8'd0, green: 8'd255, blue: x};
			else if (h < 1020)
				c = '{red: 8'd0, green: x, blue: 8'd255};
			else if (h < 1275)
				c = '{red: x, green: 8'd0, blue: 8'd255};
			else
				c = '{red: 8'd255, green: 8'd0, blue: x};
		end
		return c;
	endfunction

	// last pixel of a frame still uses the old scale
	task automatic color_pixel(input pixel_t px);
		if (px.depth_mm > frame_peak)
			frame_peak = px.depth_mm;
		expected_colors.push_back(hue_color(px.depth_mm, scale_now));
		if (px.frame_end) begin
			scale_now  = frame_peak;
			frame_peak = '0;
		end
	endtask

	task automatic add_pixel(input logic [DEPTH_BITS-1:0] depth, input bit last,
			input bit drain);
		queued_pixel_t q;
		q.px.depth_mm  = depth;
		q.px.frame_end = last;
		q.drain_first  = drain;
		pixel_queue.push_back(q);
	endtask

	task automatic check_color(input color_t got);
		color_t want;
		if (expected_colors.size() == 0) begin
			$error("color beat with nothing expected: %h", got);
			errors++;
			return;
		end
		want = expected_colors.pop_front();
		if (got.red !== want.red) begin
			$error("red: expected %0d, got %0d", want.red, got.red);
			errors++;
		end
		if (got.green !== want.green) begin
			$error("green: expected %0d, got %0d", want.green, got.green);
			errors++;
		end
		if (got.blue !== want.blue) begin
			$error("blue: expected %0d, got %0d", want.blue, got.blue);
			errors++;
		end
	endtask

	// pixel driver: bursts with random gaps, optional drain before a beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pixel       <= '0;
		end else begin
			if (pixel_valid && !pixel_stall)
				color_pixel(pixel);
			if (!pixel_valid || !pixel_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					pixel_valid <= 1'b0;
				end else if (pixel_queue.size() > 0 &&
						!(pixel_queue[0].drain_first && expected_colors.size() > 0)) begin
					pixel       <= pixel_queue[0].px;
					pixel_valid <= 1'b1;
					void'(pixel_queue.pop_front());
					burst_left--;
					if (burst_left <= 0) begin
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
							: $urandom_range(1, 24);
					end
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// color stall pattern: a random mode, redrawn when its random span runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			unique case (stall_mode)
				STALL_NONE: color_stall <= 1'b0;
				STALL_LIGHT: color_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: color_stall <= ($urandom_range(0, 3) != 0);
				default: begin
					if (hold_left == 0) begin
						hold_left = $urandom_range(1, 40);
						held      = ~held;
					end else begin
						hold_left--;
					end
					color_stall <= held;
				end
			endcase
		end
	end

	// color monitor
	always @(posedge clk) begin
		if (arst_n && color_valid && !color_stall)
			check_color(color);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("depth_to_hue_colormap test failed");
			$finish;
		end
	end

	initial begin
		int unsigned           frame_len;
		int unsigned           top;
		int unsigned           pick;
		int                    n;
		bit                    zero_frame;
		logic [DEPTH_BITS-1:0] d;

		// reset scale is 6000: invalid pixel, sector edges, beyond scale
		add_pixel(14'd0, 1'b0, 1'b0);
		add_pixel(14'd1, 1'b0, 1'b0);
		add_pixel(14'd1000, 1'b0, 1'b0);
		add_pixel(14'd2000, 1'b0, 1'b0);
		add_pixel(14'd3000, 1'b0, 1'b0);
		add_pixel(14'd4000, 1'b0, 1'b0);
		add_pixel(14'd5000, 1'b0, 1'b0);
		add_pixel(14'd5999, 1'b0, 1'b0);
		add_pixel(14'd6000, 1'b0, 1'b0);
		add_pixel(14'd16383, 1'b0, 1'b0);
		add_pixel(14'd8191, 1'b1, 1'b0);
		// scale now full range; a frame of 16383 ending on a zero pixel keeps it there
		add_pixel(14'd16383, 1'b0, 1'b0);
		add_pixel(14'd0, 1'b1, 1'b1);
		// still full-range scale: mid, top and bottom depths
		add_pixel(14'd5000, 1'b0, 1'b0);
		add_pixel(14'd16383, 1'b0, 1'b0);
		add_pixel(14'd1, 1'b1, 1'b0);
		// scale 16383, then a single-pixel frame setting scale 1
		add_pixel(14'd1, 1'b1, 1'b0);
		add_pixel(14'd16383, 1'b0, 1'b0);
		add_pixel(14'd2, 1'b0, 1'b0);
		add_pixel(14'd1, 1'b1, 1'b0);
		add_pixel(14'd10922, 1'b0, 1'b1);
		add_pixel(14'd5461, 1'b1, 1'b0);

		// random frames of varied depth range
		n = pixel_queue.size();
		while (n < PIXEL_COUNT) begin
			frame_len  = $urandom_range(1, 30);
			zero_frame = ($urandom_range(0, 24) == 0);
			case ($urandom_range(0, 3))
				0: top = $urandom_range(1, 16383);
				1: top = $urandom_range(1, 64);
				2: top = $urandom_range(5000, 7000);
				default: top = 16383;
			endcase
			for (int k = 0; k < frame_len; k++) begin
				pick = $urandom_range(0, 19);
				if (zero_frame || pick == 0)
					d = '0;
				else if (pick == 1)
					d = DEPTH_BITS'($urandom_range(0, 16383));
				else
					d = DEPTH_BITS'($urandom_range(1, top));
				add_pixel(d, k == frame_len - 1, n % 300 == 299);
				n++;
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_queue.size() > 0 || pixel_valid)
			@(posedge clk);
		while (expected_colors.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("depth_to_hue_colormap test passed");
		else
			$display("depth_to_hue_colormap test failed");
		$finish;
	end

endmodule
